### hdl/e2c_pkg.sv
// e2c_pkg: shared types, second-count constants and the divisor table for
// the epoch-to-calendar converter. No dependencies.
`default_nettype none

package e2c_pkg;

    localparam logic [31:0] SEC_MIN     = 32'd60;
    localparam logic [31:0] SEC_HOUR    = 32'd3600;
    localparam logic [31:0] SEC_DAY     = 32'd86400;
    localparam logic [31:0] SEC_YEAR    = 32'd31536000;
    localparam logic [31:0] SEC_GROUP4  = 32'd126230400;
    localparam logic [31:0] SEC_CENTURY = 32'd3155673600;
    // 1970-01-01 to 2000-03-01
    localparam logic [31:0] REBASE_SEC  = 32'd951868800;
    localparam logic [11:0] BASE_YEAR   = 12'd2000;

    // Top quotient bit of each division phase
    localparam logic [3:0] K_G4   = 4'd4;
    localparam logic [3:0] K_YR   = 4'd1;   // two bits only: clamps 4 years to 3
    localparam logic [3:0] K_DAY  = 4'd8;
    localparam logic [3:0] K_HOUR = 4'd4;
    localparam logic [3:0] K_MIN  = 4'd5;
    localparam logic [3:0] LAST_MONTH_IDX = 4'd11;
    localparam logic [3:0] FIRST_NEXT_YEAR_IDX = 4'd10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CEN,
        ST_G4,
        ST_YR,
        ST_DAY,
        ST_HOUR,
        ST_MIN,
        ST_MONTH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        ge;
        logic [31:0] diff;
    } t_cs;

    // March-based month lengths, February last
    function automatic logic [31:0] month_len(input logic [3:0] idx);
        logic [31:0] len;
        unique case (idx)
            4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: len = 32'd31;
            4'd1, 4'd3, 4'd6, 4'd8:                    len = 32'd30;
            4'd11:                                     len = 32'd29;
            default:                                   len = 32'd0;
        endcase
        return len;
    endfunction

    // Divisor for the current step: a span (shifted by k but for the century), or the month length
    function automatic logic [31:0] divisor(input t_state st, input logic [3:0] k);
        logic [31:0] dv;
        unique case (st)
            ST_CEN:   dv = SEC_CENTURY;
            ST_G4:    dv = SEC_GROUP4 << k;
            ST_YR:    dv = SEC_YEAR << k;
            ST_DAY:   dv = SEC_DAY << k;
            ST_HOUR:  dv = SEC_HOUR << k;
            ST_MIN:   dv = SEC_MIN << k;
            ST_MONTH: dv = month_len(k);
            default:  dv = '0;
        endcase
        return dv;
    endfunction

endpackage

`default_nettype wire

### hdl/e2c_cmpsub.sv
// e2c_cmpsub: the shared compare-and-subtract unit.
// Depends on e2c_pkg (t_cs).
`default_nettype none

module e2c_cmpsub (
    input  wire logic [31:0]   i_minuend,
    input  wire logic [31:0]   i_subtrahend,
    output e2c_pkg::t_cs       o_res
);

    logic [32:0] w_diff;

    assign w_diff     = {1'b0, i_minuend} - {1'b0, i_subtrahend};
    assign o_res.ge   = ~w_diff[32];
    assign o_res.diff = w_diff[31:0];

endmodule

`default_nettype wire

### hdl/epoch_seconds_to_calendar.sv
// epoch_seconds_to_calendar: top level, sequencer and output register.
// Depends on e2c_pkg and e2c_cmpsub.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall with i_epoch_seconds. A word is
//   taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall with o_year .. o_second. A word
//   leaves at an edge with o_out_valid high and i_out_stall low.
//   One shared 32-bit compare/subtract unit does all the work, one restoring
//   quotient bit (or one month step) per cycle, in the steps century,
//   4-year group, year, day, hour and minute, then the month walk and a
//   final step that loads the result. A new word is accepted only once
//   the previous one has finished conversion; o_in_stall is high the
//   whole time a word is in conversion.
//   The result sits in its own output register, so a new word is accepted
//   while the previous result waits on a stalled receiver. If the receiver
//   is still stalling when the next result is ready, the sequencer holds
//   in its final state and the input stays stalled.
//   Reset (i_rst_n low, synchronous) empties the sequencer and the output
//   register; nothing else needs clearing.
//   Inputs before 2000-03-01 wrap modulo 2^32 and come out near 2106..2136.
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [31:0] i_epoch_seconds,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [11:0] o_year,
    output      logic [3:0]  o_month,
    output      logic [4:0]  o_day,
    output      logic [4:0]  o_hour,
    output      logic [5:0]  o_minute,
    output      logic [5:0]  o_second
);

    e2c_pkg::t_state r_state, n_state;

    // working remainder, quotient shifter, step counter / month index
    logic [31:0] r_rem, n_rem;
    logic [8:0]  r_q, n_q;
    logic [3:0]  r_k, n_k;

    // partial results
    logic        r_cen, n_cen;
    logic [4:0]  r_g4, n_g4;
    logic [1:0]  r_yr, n_yr;
    logic [8:0]  r_doy, n_doy;
    logic [4:0]  r_hour, n_hour;
    logic [5:0]  r_min, n_min;
    logic [5:0]  r_sec, n_sec;

    // output register
    logic        r_ovalid, n_ovalid;
    logic [11:0] r_year, n_year;
    logic [3:0]  r_month, n_month;
    logic [4:0]  r_day, n_day;
    logic [4:0]  r_ohour, n_ohour;
    logic [5:0]  r_omin, n_omin;
    logic [5:0]  r_osec, n_osec;

    logic [31:0]  w_div;
    e2c_pkg::t_cs w_cs;
    logic [8:0]   w_qn;      // quotient with this step's bit shifted in
    logic [31:0]  w_remn;    // remainder after this step
    logic         w_wrap;    // January/February: next year

    assign w_div  = e2c_pkg::divisor(r_state, r_k);
    assign w_qn   = {r_q[7:0], w_cs.ge};
    assign w_remn = w_cs.ge ? w_cs.diff : r_rem;
    assign w_wrap = (r_k >= e2c_pkg::FIRST_NEXT_YEAR_IDX);

    e2c_cmpsub u_cmpsub (
        .i_minuend    (r_rem),
        .i_subtrahend (w_div),
        .o_res        (w_cs)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= e2c_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_k     <= n_k;
        r_cen   <= n_cen;
        r_g4    <= n_g4;
        r_yr    <= n_yr;
        r_doy   <= n_doy;
        r_hour  <= n_hour;
        r_min   <= n_min;
        r_sec   <= n_sec;
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_ohour <= n_ohour;
        r_omin  <= n_omin;
        r_osec  <= n_osec;
    end

    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_q      = r_q;
        n_k      = r_k;
        n_cen    = r_cen;
        n_g4     = r_g4;
        n_yr     = r_yr;
        n_doy    = r_doy;
        n_hour   = r_hour;
        n_min    = r_min;
        n_sec    = r_sec;
        n_ovalid = r_ovalid & i_out_stall;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_ohour  = r_ohour;
        n_omin   = r_omin;
        n_osec   = r_osec;

        unique case (r_state)
            e2c_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    // rebase to 2000-03-01, wrapping
                    n_rem   = i_epoch_seconds - e2c_pkg::REBASE_SEC;
                    n_q     = '0;
                    n_k     = '0;
                    n_state = e2c_pkg::ST_CEN;
                end
            end
            e2c_pkg::ST_CEN: begin
                // 400-year count is always zero for a 32-bit input
                n_rem   = w_remn;
                n_cen   = w_cs.ge;
                n_q     = '0;
                n_k     = e2c_pkg::K_G4;
                n_state = e2c_pkg::ST_G4;
            end
            e2c_pkg::ST_G4, e2c_pkg::ST_YR, e2c_pkg::ST_DAY,
            e2c_pkg::ST_HOUR, e2c_pkg::ST_MIN: begin
                n_rem = w_remn;
                n_q   = w_qn;
                n_k   = r_k - 4'd1;
                if (r_k == 4'd0) begin
                    n_q = '0;
                    unique case (r_state)
                        e2c_pkg::ST_G4: begin
                            n_g4    = w_qn[4:0];
                            n_k     = e2c_pkg::K_YR;
                            n_state = e2c_pkg::ST_YR;
                        end
                        e2c_pkg::ST_YR: begin
                            n_yr    = w_qn[1:0];
                            n_k     = e2c_pkg::K_DAY;
                            n_state = e2c_pkg::ST_DAY;
                        end
                        e2c_pkg::ST_DAY: begin
                            n_doy   = w_qn;
                            n_k     = e2c_pkg::K_HOUR;
                            n_state = e2c_pkg::ST_HOUR;
                        end
                        e2c_pkg::ST_HOUR: begin
                            n_hour  = w_qn[4:0];
                            n_k     = e2c_pkg::K_MIN;
                            n_state = e2c_pkg::ST_MIN;
                        end
                        default: begin
                            // minutes done; remainder is seconds, start month walk
                            n_min   = w_qn[5:0];
                            n_sec   = w_remn[5:0];
                            n_rem   = {23'd0, r_doy};
                            n_k     = '0;
                            n_state = e2c_pkg::ST_MONTH;
                        end
                    endcase
                end
            end
            e2c_pkg::ST_MONTH: begin
                if (w_cs.ge && (r_k < e2c_pkg::LAST_MONTH_IDX)) begin
                    n_rem = w_cs.diff;
                    n_k   = r_k + 4'd1;
                end else begin
                    n_state = e2c_pkg::ST_DONE;
                end
            end
            e2c_pkg::ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_year   = e2c_pkg::BASE_YEAR
                             + (r_cen ? 12'd100 : 12'd0)
                             + {5'd0, r_g4, 2'b00}
                             + {10'd0, r_yr}
                             + {11'd0, w_wrap};
                    n_month  = w_wrap ? (r_k - 4'd9) : (r_k + 4'd3);
                    n_day    = r_rem[4:0] + 5'd1;
                    n_ohour  = r_hour;
                    n_omin   = r_min;
                    n_osec   = r_sec;
                    n_state  = e2c_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = e2c_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != e2c_pkg::ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_year      = r_year;
    assign o_month     = r_month;
    assign o_day       = r_day;
    assign o_hour      = r_ohour;
    assign o_minute    = r_omin;
    assign o_second    = r_osec;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == e2c_pkg::ST_CEN))
        else $error("accepted word did not start conversion");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !$past(r_ovalid)) |-> ($past(r_state) == e2c_pkg::ST_DONE))
        else $error("result appeared outside the final step");

    a_month_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == e2c_pkg::ST_MONTH) |-> (r_k <= e2c_pkg::LAST_MONTH_IDX))
        else $error("month walk ran past the table");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_day != 5'd0 && o_month != 4'd0 && o_month <= 4'd12
                         && o_hour <= 5'd23 && o_minute <= 6'd59 && o_second <= 6'd59))
        else $error("calendar field out of range");
`endif

endmodule

`default_nettype wire

### verif/testbench.sv
// testbench: self-checking bench for epoch_seconds_to_calendar.
// Needs only the block itself; expected dates come from a local civil-date
// predictor. Directed edge cases first, then random epochs at three idling mixes.

module testbench;

    // ---------------------------------------------------------------- timing
    // The limit leaves room for each word's conversion and for the random
    // gaps and stalls.
    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned DRAIN_CYCLES  = 48;   // a little over worst-case latency
    localparam int unsigned REPORT_MAX    = 10;

    // ------------------------------------------------------ calendar spans
    // Spans are held at 64 bits so that the 400-year span stays exact.
    localparam longint unsigned DAY_SECS   = 64'd86400;
    localparam longint unsigned SPAN_YEAR  = 64'd365 * DAY_SECS;
    localparam longint unsigned SPAN_4Y    = 64'd4 * SPAN_YEAR + DAY_SECS;
    localparam longint unsigned SPAN_100Y  = 64'd25 * SPAN_4Y - DAY_SECS;
    localparam longint unsigned SPAN_400Y  = 64'd4 * SPAN_100Y + DAY_SECS;
    localparam int unsigned     FIRST_YEAR = 2000;

    // Seconds from 1970-01-01 to 2000-03-01, and 32-bit copies for stimulus
    localparam logic [31:0] MARCH_2000 = 32'd951868800;
    localparam logic [31:0] DAY_32     = 32'(DAY_SECS);
    localparam logic [31:0] YEAR_32    = 32'(SPAN_YEAR);
    localparam logic [31:0] QUAD_32    = 32'(SPAN_4Y);
    localparam logic [31:0] CENTURY_32 = 32'(SPAN_100Y);

    // Month table starts at March; indexes from January on belong to next year
    localparam int unsigned MARCH_DAYS [12] = '{31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 31, 29};
    localparam int unsigned LAST_MONTH_IDX = 11;
    localparam int unsigned JANUARY_IDX    = 10;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_calendar;

    typedef struct {
        logic [31:0] epoch;
        t_calendar   cal;
    } t_pending_date;

    // ----------------------------------------------------------- DUT ports
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [31:0] i_epoch_seconds = '0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [11:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [4:0]  o_hour;
    logic [5:0]  o_minute;
    logic [5:0]  o_second;

    // ------------------------------------------------------- bench state
    t_pending_date pending_dates[$];     // dates still owed by the block, oldest first
    int unsigned   mismatches         = 0;
    int unsigned   cycle_count        = 0;
    int unsigned   sender_idle_pct    = 37;
    int unsigned   receiver_stall_pct = 62;

    epoch_seconds_to_calendar dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_epoch_seconds (i_epoch_seconds),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_year          (o_year),
        .o_month         (o_month),
        .o_day           (o_day),
        .o_hour          (o_hour),
        .o_minute        (o_minute),
        .o_second        (o_second)
    );

    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------ predictor
    // Rebase to 2000-03-01 with a 32-bit wrap, peel off 400/100/4/1-year
    // groups from March, clamp a fourth century or year to the third (that
    // is the leap day at the group's end), then walk the March-based months.
    function automatic t_calendar civil_from_epoch(input logic [31:0] secs);
        logic [31:0]     since_march;
        longint unsigned rest, n400, n100, n4, n1, full_year;
        int unsigned     day_in_year, sec_in_day, mon_idx, day_left;
        t_calendar       c;
        since_march = secs - MARCH_2000;
        rest = 64'(since_march);
        n400 = rest / SPAN_400Y;
        rest = rest % SPAN_400Y;
        n100 = rest / SPAN_100Y;
        rest = rest % SPAN_100Y;
        if (n100 == 4) begin
            n100 = 3;
            rest += SPAN_100Y;
        end
        n4   = rest / SPAN_4Y;
        rest = rest % SPAN_4Y;
        n1   = rest / SPAN_YEAR;
        rest = rest % SPAN_YEAR;
        if (n1 == 4) begin
            n1 = 3;
            rest += SPAN_YEAR;
        end
        day_in_year = int'(rest / DAY_SECS);
        sec_in_day  = int'(rest % DAY_SECS);
        full_year   = FIRST_YEAR + 400 * n400 + 100 * n100 + 4 * n4 + n1;

        mon_idx  = 0;
        day_left = day_in_year;
        while (mon_idx < LAST_MONTH_IDX && day_left >= MARCH_DAYS[mon_idx]) begin
            day_left -= MARCH_DAYS[mon_idx];
            mon_idx++;
        end
        // January and February roll into the following year
        if (mon_idx >= JANUARY_IDX) begin
            c.month = 4'(mon_idx - (JANUARY_IDX - 1));
            full_year++;
        end else begin
            c.month = 4'(mon_idx + 3);
        end
        c.year   = 12'(full_year);
        c.day    = 5'(day_left + 1);
        c.hour   = 5'(sec_in_day / 3600);
        c.minute = 6'((sec_in_day % 3600) / 60);
        c.second = 6'(sec_in_day % 60);
        return c;
    endfunction

    // ------------------------------------------------------------- drivers
    // Receiver back-pressure, redrawn every falling edge.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // Offer one epoch word: optional idle gap, then hold valid and the payload
    // steady until the block takes it. The expected date is queued on accept.
    task automatic send_epoch(input logic [31:0] secs);
        t_pending_date entry;
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (o_in_stall);
        entry.epoch = secs;
        entry.cal   = civil_from_epoch(secs);
        pending_dates.push_back(entry);
    endtask

    // ------------------------------------------------------------- checker
    task automatic flag_mismatch(input string field, input logic [31:0] epoch,
                                 input longint unsigned want, input longint unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on %s for epoch %0d: expected %0d, got %0d",
                     field, epoch, want, got);
    endtask

    always @(posedge i_clk) begin
        t_pending_date want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_dates.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result word %0d-%0d-%0d %0d:%0d:%0d",
                             o_year, o_month, o_day, o_hour, o_minute, o_second);
            end else begin
                want = pending_dates.pop_front();
                if (o_year !== want.cal.year)
                    flag_mismatch("year", want.epoch, want.cal.year, o_year);
                if (o_month !== want.cal.month)
                    flag_mismatch("month", want.epoch, want.cal.month, o_month);
                if (o_day !== want.cal.day)
                    flag_mismatch("day", want.epoch, want.cal.day, o_day);
                if (o_hour !== want.cal.hour)
                    flag_mismatch("hour", want.epoch, want.cal.hour, o_hour);
                if (o_minute !== want.cal.minute)
                    flag_mismatch("minute", want.epoch, want.cal.minute, o_minute);
                if (o_second !== want.cal.second)
                    flag_mismatch("second", want.epoch, want.cal.second, o_second);
            end
        end
    end

    // --------------------------------------------------------------- tests
    // Field extremes and bit patterns; epoch 0 lands in the
    // wrapped range around 2106..2136.
    task automatic test_field_extremes;
        send_epoch(32'h0000_0000);
        send_epoch(32'hFFFF_FFFF);
        send_epoch(32'h7FFF_FFFF);
        send_epoch(32'h8000_0000);
        send_epoch(32'h5555_5555);
        send_epoch(32'hAAAA_AAAA);
    endtask

    // Day, year, leap-day and century boundaries around the rebase point.
    task automatic test_calendar_edges;
        send_epoch(MARCH_2000);                               // 2000-03-01 00:00:00
        send_epoch(MARCH_2000 - 1);                           // wrap: largest offset
        send_epoch(MARCH_2000 + 32'd86399);                   // 23:59:59, top h/m/s
        send_epoch(MARCH_2000 + 32'd306 * DAY_32 - 1);        // 2000-12-31 23:59:59
        send_epoch(MARCH_2000 + 32'd306 * DAY_32);            // 2001-01-01
        send_epoch(MARCH_2000 + YEAR_32 - 1);                 // 2001-02-28 end
        send_epoch(MARCH_2000 + 32'd4 * YEAR_32 - 1);         // 2004-02-28 end
        send_epoch(MARCH_2000 + QUAD_32 - DAY_32);            // 2004-02-29, year clamp
        send_epoch(MARCH_2000 + QUAD_32 - 1);                 // 2004-02-29 23:59:59
        send_epoch(MARCH_2000 + QUAD_32);                     // 2004-03-01
        send_epoch(MARCH_2000 + CENTURY_32 - 1);              // 2100-02-28, no leap day
        send_epoch(MARCH_2000 + CENTURY_32);                  // 2100-03-01
        send_epoch(MARCH_2000 + CENTURY_32 + QUAD_32 - DAY_32); // 2104-02-29
    endtask

    // Half uniform epochs, the rest clustered on midnights, leap-day group
    // ends and the 2100 century edge where the carry logic works hardest.
    task automatic test_random_dates(input int unsigned count);
        logic [31:0] secs;
        int unsigned pick;
        for (int unsigned n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 50)
                secs = $urandom();
            else if (pick < 70)
                secs = DAY_32 * $urandom_range(49710) + $urandom_range(4) - 2;
            else if (pick < 90)
                secs = MARCH_2000 + QUAD_32 * $urandom_range(34, 1) - 2 * DAY_32
                     + $urandom_range(3 * 86400);
            else
                secs = MARCH_2000 + CENTURY_32 - 3 * DAY_32 + $urandom_range(6 * 86400);
            send_epoch(secs);
        end
    endtask

    // ------------------------------------------------------------ sequence
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles 37 %, receiver stalls 62 %
        test_field_extremes;
        test_calendar_edges;
        test_random_dates(300);

        // roles swapped
        sender_idle_pct    = 62;
        receiver_stall_pct = 37;
        test_random_dates(300);

        // full rate on both sides
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        test_random_dates(300);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_dates.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
hdl/e2c_pkg.sv
hdl/e2c_cmpsub.sv
hdl/epoch_seconds_to_calendar.sv
verif/testbench.sv
